// File: rtl/etld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etld_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ESC_BYTE = 8'h1F;
  localparam logic [ByteW-1:0] TAB_BYTE = 8'h09;
  localparam logic [ByteW-1:0] LF_BYTE  = 8'h0A;
  localparam logic [ByteW-1:0] CR_BYTE  = 8'h0D;
  localparam logic [ByteW-1:0] NUL_BYTE = 8'h00;
  localparam logic [ByteW-1:0] CHAR_N   = 8'h6E;
  localparam logic [ByteW-1:0] CHAR_R   = 8'h72;
  localparam logic [ByteW-1:0] CHAR_T   = 8'h74;
  localparam logic [ByteW-1:0] CHAR_E   = 8'h65;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN_ESC = 3'd1,
    ST_TRUNC_ESC   = 3'd2,
    ST_TRUNC_INPUT = 3'd3,
    ST_BAD_UTF8    = 3'd4
  } status_e;

  // allowed range of the next utf-8 continuation byte
  typedef enum logic [2:0] {
    RANGE_80_BF = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } range_e;

  typedef struct packed {
    logic       escape_pending;
    logic       swallowing;
    status_e    line_status;
    logic [1:0] utf8_left;
    range_e     utf8_range;
  } etld_state_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    status_e          status;
  } etld_result_t;

  localparam etld_state_t STATE_RESET = '{
    escape_pending: 1'b0,
    swallowing:     1'b0,
    line_status:    ST_OK,
    utf8_left:      2'd0,
    utf8_range:     RANGE_80_BF
  };

endpackage

`default_nettype wire

// File: rtl/escaped_tab_line_decoder_unit.sv
// escaped tab-separated line decoder
//
// input channel: one raw byte per request (in_valid_i / in_ready_o / in_byte_i).
// output channel: zero or one result per input byte (out_valid_o / out_ready_i)
//   kind_o    0 data byte, 1 field end, 2 line end (closes the last field)
//   out_byte_o decoded byte for data, zero otherwise
//   status_o  line status on line end, zero otherwise
// escapes 0x1f + n/r/t/e decode to lf/cr/tab/0x1f; raw bytes are checked as
// strict utf-8. cr or lf ends a line, directly following cr/lf bytes are
// dropped; a zero byte ends the buffer and always gives a line end.
//
// a byte accepted lands in the input register and is decoded into the result
// register once it is free or being emptied, shown from then on. throughput
// is one byte per cycle while the receiver does not stall, set by the single
// decode pass between input and result register. bytes that produce no result
// simply leave the result register empty. reset clears the decoder state (no
// escape, no error, no utf-8 sequence) and both valid flags. when stalled,
// the result register holds; the input register fills, then in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none

module escaped_tab_line_decoder_unit import etld_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [ByteW-1:0]      out_byte_o,
  output logic [2:0]            status_o
);

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  // decoder state
  etld_state_t state_q;
  etld_state_t state_d;

  // result register
  logic         out_valid_q;
  etld_result_t res_q;
  etld_result_t res_d;
  logic         res_valid_d;

  // result register is free or being emptied this cycle
  logic advance;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  etld_step u_step (
    .byte_i      (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid_d),
    .res_o       (res_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid_d;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (advance && in_valid_q && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign out_byte_o  = res_q.data;
  assign status_o    = res_q.status;

endmodule

`default_nettype wire

// File: rtl/etld_step.sv
`timescale 1ns / 1ps
`default_nettype none

module etld_step import etld_pkg::*; (
  input  wire logic [ByteW-1:0] byte_i,
  input  wire etld_state_t      state_i,
  output etld_state_t           state_o,
  output logic                  res_valid_o,
  output etld_result_t          res_o
);

  // first error is held, bad utf-8 always wins
  function automatic status_e hold_error(status_e cur, status_e e);
    if (cur == ST_OK || e == ST_BAD_UTF8) begin
      return e;
    end
    return cur;
  endfunction

  function automatic etld_state_t utf8_check(etld_state_t s, logic [ByteW-1:0] b);
    logic [ByteW-1:0] lo;
    logic [ByteW-1:0] hi;
    etld_state_t      r;
    r  = s;
    lo = 8'h80;
    hi = 8'hBF;
    if (s.utf8_left != 2'd0) begin
      case (s.utf8_range)
        RANGE_A0_BF: lo = 8'hA0;
        RANGE_80_9F: hi = 8'h9F;
        RANGE_90_BF: lo = 8'h90;
        RANGE_80_8F: hi = 8'h8F;
        default:     lo = 8'h80;
      endcase
      if (b >= lo && b <= hi) begin
        r.utf8_left = s.utf8_left - 2'd1;
      end else begin
        r.line_status = hold_error(s.line_status, ST_BAD_UTF8);
        r.utf8_left   = 2'd0;
      end
      r.utf8_range = RANGE_80_BF;
    end else if (b >= 8'h80) begin
      if (b < 8'hC2 || b > 8'hF4) begin
        r.line_status = hold_error(s.line_status, ST_BAD_UTF8);
      end else if (b < 8'hE0) begin
        r.utf8_left  = 2'd1;
        r.utf8_range = RANGE_80_BF;
      end else if (b < 8'hF0) begin
        r.utf8_left  = 2'd2;
        r.utf8_range = (b == 8'hE0) ? RANGE_A0_BF :
                       (b == 8'hED) ? RANGE_80_9F : RANGE_80_BF;
      end else begin
        r.utf8_left  = 2'd3;
        r.utf8_range = (b == 8'hF0) ? RANGE_90_BF :
                       (b == 8'hF4) ? RANGE_80_8F : RANGE_80_BF;
      end
    end
    return r;
  endfunction

  etld_state_t      s;
  logic [ByteW-1:0] dec;
  logic             dec_ok;

  always_comb begin
    s           = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, data: '0, status: ST_OK};
    dec         = '0;
    dec_ok      = 1'b1;

    unique case (byte_i)
      CHAR_N:  dec = LF_BYTE;
      CHAR_R:  dec = CR_BYTE;
      CHAR_T:  dec = TAB_BYTE;
      CHAR_E:  dec = ESC_BYTE;
      default: dec_ok = 1'b0;
    endcase

    if (byte_i == NUL_BYTE) begin
      // end of buffer
      if (s.utf8_left != 2'd0) s.line_status = hold_error(s.line_status, ST_BAD_UTF8);
      if (s.escape_pending) s.line_status = hold_error(s.line_status, ST_TRUNC_ESC);
      s.line_status = hold_error(s.line_status, ST_TRUNC_INPUT);
      res_valid_o   = 1'b1;
      res_o.kind    = KIND_LINE_END;
      res_o.status  = s.line_status;
      s             = STATE_RESET;
    end else if (byte_i == CR_BYTE || byte_i == LF_BYTE) begin
      if (!s.swallowing) begin
        s = utf8_check(s, byte_i);
        if (s.escape_pending) s.line_status = hold_error(s.line_status, ST_TRUNC_ESC);
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_LINE_END;
        res_o.status = s.line_status;
        s            = STATE_RESET;
        s.swallowing = 1'b1;
      end
    end else begin
      s.swallowing = 1'b0;
      s = utf8_check(s, byte_i);
      if (s.escape_pending) begin
        s.escape_pending = 1'b0;
        if (byte_i == TAB_BYTE) begin
          s.line_status = hold_error(s.line_status, ST_TRUNC_ESC);
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_FIELD_END;
        end else if (!dec_ok) begin
          s.line_status = hold_error(s.line_status, ST_UNKNOWN_ESC);
        end else if (s.line_status == ST_OK) begin
          res_valid_o = 1'b1;
          res_o.data  = dec;
        end
      end else if (byte_i == ESC_BYTE) begin
        s.escape_pending = 1'b1;
      end else if (byte_i == TAB_BYTE) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_FIELD_END;
      end else if (s.line_status == ST_OK) begin
        res_valid_o = 1'b1;
        res_o.data  = byte_i;
      end
    end
    state_o = s;
  end

endmodule

`default_nettype wire

// File: rtl/etld_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module etld_assert import etld_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       kind_o,
  input wire logic [ByteW-1:0] out_byte_o,
  input wire logic [2:0]       status_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(out_byte_o) && $stable(status_o))
    else $error("stalled result changed");

  // only field end, line end and data kinds are produced
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o == KIND_DATA || kind_o == KIND_FIELD_END
      || kind_o == KIND_LINE_END)
    else $error("illegal result kind");

  // status only travels with a line end
  a_status_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_LINE_END |-> status_o == ST_OK)
    else $error("status outside line end");

  // a line end carries a legal status and no data byte
  a_nul_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_LINE_END |-> status_o <= ST_BAD_UTF8
      && out_byte_o == NUL_BYTE)
    else $error("bad line end payload");

  // an empty result register never blocks the input
  a_in_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

endmodule

bind escaped_tab_line_decoder_unit etld_assert u_etld_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .out_byte_o  (out_byte_o),
  .status_o    (status_o)
);

`default_nettype wire
